// ===== design/imu_bias_calibrate_yaw_integrate_top_defines.svh =====
// ---------------------------------------------------------------------------
// IMU calibration assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_YAW_INTEGRATE_TOP_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_YAW_INTEGRATE_TOP_DEFINES_SVH

// same-cycle implication
`define IMU_CAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define IMU_CAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== design/imu_cal_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU calibration package
// Widths, fixed-point constants and sequencer states.
// ---------------------------------------------------------------------------
package imu_cal_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int DT_W              = 20;
  localparam int CFG_W             = 16;
  localparam int OUT_W             = 224;
  localparam int DIVD_W            = 53;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd100;

  localparam logic [26:0] RATE_K  = 27'd74961321;  // pi/180 in Q32
  localparam logic [19:0] ACC_K   = 20'd642908;    // 9.81 in Q16
  localparam logic signed [32:0] GRAV_Q16 = 33'sd642908;

  localparam logic signed [41:0] PI_Q28     = 42'sd843314857;
  localparam logic signed [41:0] TWO_PI_Q28 = 42'sd1686629713;
  localparam logic [13:0] YAW_DIV = 14'd15625;
  localparam logic [12:0] YAW_RND = 13'd7812;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_MLOAD  = 14'b00000000000010,
    ST_MUL    = 14'b00000000000100,
    ST_SCALE  = 14'b00000000001000,
    ST_ACC    = 14'b00000000010000,
    ST_DLOAD  = 14'b00000000100000,
    ST_DIV    = 14'b00000001000000,
    ST_DOFF   = 14'b00000010000000,
    ST_CORR   = 14'b00000100000000,
    ST_YMLOAD = 14'b00001000000000,
    ST_YDLOAD = 14'b00010000000000,
    ST_YAW1   = 14'b00100000000000,
    ST_YAW2   = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_t;

endpackage

// ===== design/imu_bias_calibrate_yaw_integrate_top.sv =====
// Each of the six axes of a sample beat is scaled by a bit-serial shift-add
// multiplier, one multiplier bit per cycle, and the yaw step goes through the
// same multiplier, with the 20-bit delta_time as the multiplier, and then a
// restoring divider, one quotient bit per cycle over 53 bits. The sample that
// completes a calibration also runs the six offset divisions on that divider.
// A start beat yields no result and leaves the block ready for the next beat.
// The finished result sits in an output register, so the next beat is taken
// while it waits.
// ---------------------------------------------------------------------------
// IMU bias calibration and yaw integration
// Scales six IMU axes, averages biases on request, integrates yaw.
// ---------------------------------------------------------------------------
module imu_bias_calibrate_yaw_integrate_top #(
  parameter int SAMPLE_WIDTH  = imu_cal_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNTER_WIDTH = imu_cal_pkg::COUNTER_WIDTH_DEF,
  localparam int IN_W = ((6 * SAMPLE_WIDTH + imu_cal_pkg::DT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z, delta_time
  input  logic [IN_W-1:0]                 in_tdata,
  // kind
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, heading
  output logic [imu_cal_pkg::OUT_W-1:0]   out_tdata,
  // calib_done, calibrating
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [imu_cal_pkg::CFG_W-1:0]   cfg_wr_data
);
  import imu_cal_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COUNTER_WIDTH;
  localparam int MB_W  = (SW > DT_W) ? SW : DT_W;
  localparam int MUL_W = (SW + 27 > DIVD_W) ? SW + 27 : DIVD_W;
  localparam int DV_W  = (CW > 14) ? CW : 14;
  localparam int BC_W  = $clog2(DIVD_W);
  localparam logic [31:0] CMAX = 32'((64'd1 << CW) - 64'd1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cfg_r;
  logic                active_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       latched_r;
  logic                done_r;
  logic [2:0]          axis_r;
  logic [BC_W-1:0]     bcnt_r;
  logic                ph_yaw_r;
  logic                out_tvalid_r;

  logic signed [47:0]  sum_r [6];
  logic signed [31:0]  off_r [6];
  logic signed [31:0]  prev_r;
  logic signed [31:0]  yaw_r;

  logic signed [SW-1:0] raw_r [6];
  logic [DT_W-1:0]      dt_r;
  logic signed [31:0]   val_r [6];
  logic [MUL_W-1:0]     mcand_r;
  logic [MB_W-1:0]      mplier_r;
  logic [MUL_W-1:0]     prod_r;
  logic [DIVD_W-1:0]    dq_r;
  logic [DV_W-1:0]      rem_r;
  logic [DV_W-1:0]      dvs_r;
  logic                 dsign_r;
  logic signed [41:0]   y_r;
  logic [OUT_W-1:0]     out_tdata_r;
  logic [1:0]           out_tuser_r;

  logic                 in_acc, out_free, cnt_hit, last_axis, neg_axis;
  logic [CW-1:0]        n_sel;
  logic signed [SW-1:0] raw_sel;
  logic [SW-1:0]        raw_mag;
  logic [MUL_W:0]       rnd_pre, mag_s;
  logic signed [31:0]   r_clip, scaled;
  logic signed [47:0]   sum_add [6];
  logic signed [48:0]   add49;
  logic signed [32:0]   at33, d33;
  logic signed [31:0]   corr [6];
  logic signed [47:0]   s_sel;
  logic [47:0]          s_mag;
  logic signed [32:0]   t33;
  logic [32:0]          t_mag;
  logic [DV_W:0]        rem_sh;
  logic                 rem_ge;
  logic signed [31:0]   q_off;
  logic signed [41:0]   inc42, y_wrap;
  logic signed [31:0]   yaw_sat;

  function automatic logic signed [31:0] clip_mag(input logic neg, input logic [63:0] mag);
    logic signed [31:0] res;
    if (!neg) begin
      res = (mag > 64'h7FFF_FFFF) ? I32_MAX : mag[31:0];
    end else begin
      res = (mag > 64'h8000_0000) ? I32_MIN : -mag[31:0];
    end
    return res;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign cnt_hit    = (CW'(count_r + 1'b1) == latched_r);
  assign last_axis  = (axis_r == 3'd5);
  assign neg_axis   = (axis_r != 3'd1) && (axis_r != 3'd4);

  always_comb begin
    if (cfg_r == '0) begin
      n_sel = CW'(1);
    end else if (32'(cfg_r) > CMAX) begin
      n_sel = CMAX[CW-1:0];
    end else begin
      n_sel = CW'(cfg_r);
    end
  end

  // scale rounding, clipping and axis negation
  always_comb begin
    raw_sel = raw_r[axis_r];
    raw_mag = raw_sel[SW-1] ? SW'(-raw_sel) : SW'(raw_sel);
    if (axis_r < 3'd3) begin
      rnd_pre = {1'b0, prod_r} + (MUL_W+1)'(24'h80_0000);
      mag_s   = rnd_pre >> 24;
    end else begin
      rnd_pre = {1'b0, prod_r} + (MUL_W+1)'(16'h8000);
      mag_s   = rnd_pre >> 16;
    end
    r_clip = clip_mag(raw_sel[SW-1], 64'(mag_s));
    if (neg_axis) begin
      scaled = (r_clip == I32_MIN) ? I32_MAX : -r_clip;
    end else begin
      scaled = r_clip;
    end
  end

  // saturating sums and corrections
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      at33 = 33'(val_r[i]) - ((i == 5) ? GRAV_Q16 : 33'sd0);
      add49 = 49'(sum_r[i]) + 49'(at33);
      if (add49[48] != add49[47]) begin
        sum_add[i] = add49[48] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_add[i] = add49[47:0];
      end
      d33 = 33'(val_r[i]) - 33'(off_r[i]);
      if (d33[32] != d33[31]) begin
        corr[i] = d33[32] ? I32_MIN : I32_MAX;
      end else begin
        corr[i] = d33[31:0];
      end
    end
  end

  always_comb begin
    s_sel  = sum_r[axis_r];
    s_mag  = s_sel[47] ? 48'(-s_sel) : 48'(s_sel);
    t33    = 33'(val_r[2]) + 33'(prev_r);
    t_mag  = t33[32] ? 33'(-t33) : 33'(t33);
    rem_sh = {rem_r, dq_r[DIVD_W-1]};
    rem_ge = (rem_sh >= {1'b0, dvs_r});
    q_off  = clip_mag(dsign_r, 64'(dq_r));
    inc42  = dsign_r ? -42'({1'b0, dq_r[40:0]}) : 42'({1'b0, dq_r[40:0]});
    if (y_r > PI_Q28) begin
      y_wrap = y_r - TWO_PI_Q28;
    end else if (y_r < -PI_Q28) begin
      y_wrap = y_r + TWO_PI_Q28;
    end else begin
      y_wrap = y_r;
    end
    if (y_wrap > 42'(I32_MAX)) begin
      yaw_sat = I32_MAX;
    end else if (y_wrap < 42'(I32_MIN)) begin
      yaw_sat = I32_MIN;
    end else begin
      yaw_sat = y_wrap[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == KIND_SAMPLE)) state_nxt = ST_MLOAD;
      end
      ST_MLOAD:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (bcnt_r == BC_W'(MB_W - 1)) state_nxt = ph_yaw_r ? ST_YDLOAD : ST_SCALE;
      end
      ST_SCALE:  state_nxt = last_axis ? ST_ACC : ST_MLOAD;
      ST_ACC:    state_nxt = (active_r && cnt_hit) ? ST_DLOAD : ST_CORR;
      ST_DLOAD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (bcnt_r == BC_W'(DIVD_W - 1)) state_nxt = ph_yaw_r ? ST_YAW1 : ST_DOFF;
      end
      ST_DOFF:   state_nxt = last_axis ? ST_CORR : ST_DLOAD;
      ST_CORR:   state_nxt = ST_YMLOAD;
      ST_YMLOAD: state_nxt = ST_MUL;
      ST_YDLOAD: state_nxt = ST_DIV;
      ST_YAW1:   state_nxt = ST_YAW2;
      ST_YAW2:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_r        <= CFG_RESET;
      active_r     <= 1'b0;
      count_r      <= '0;
      latched_r    <= CW'(1);
      done_r       <= 1'b0;
      axis_r       <= '0;
      bcnt_r       <= '0;
      ph_yaw_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      prev_r       <= '0;
      yaw_r        <= '0;
      for (int i = 0; i < 6; i++) begin
        sum_r[i] <= '0;
        off_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if ((state_r == ST_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            axis_r   <= '0;
            ph_yaw_r <= 1'b0;
            done_r   <= 1'b0;
            if ((in_tuser[0] == KIND_START) && !active_r) begin
              active_r  <= 1'b1;
              count_r   <= '0;
              latched_r <= n_sel;
              for (int i = 0; i < 6; i++) sum_r[i] <= '0;
            end
          end
        end
        ST_MLOAD, ST_DLOAD, ST_YDLOAD: bcnt_r <= '0;
        ST_MUL, ST_DIV: bcnt_r <= bcnt_r + 1'b1;
        ST_SCALE: axis_r <= last_axis ? 3'd0 : axis_r + 3'd1;
        ST_ACC: begin
          if (active_r) begin
            for (int i = 0; i < 6; i++) sum_r[i] <= sum_add[i];
            count_r <= count_r + 1'b1;
            if (cnt_hit) begin
              done_r <= 1'b1;
              axis_r <= '0;
            end
          end
        end
        ST_DOFF: begin
          off_r[axis_r] <= q_off;
          axis_r <= last_axis ? 3'd0 : axis_r + 3'd1;
          if (last_axis) begin
            active_r <= 1'b0;
            prev_r   <= '0;
            yaw_r    <= '0;
          end
        end
        ST_CORR: ;
        ST_YMLOAD: begin
          bcnt_r   <= '0;
          ph_yaw_r <= 1'b1;
        end
        ST_YAW1: ;
        ST_YAW2: begin
          yaw_r  <= yaw_sat;
          prev_r <= val_r[2];
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 6; i++) raw_r[i] <= in_tdata[i*SW +: SW];
          dt_r <= in_tdata[6*SW +: DT_W];
        end
      end
      ST_MLOAD: begin
        mcand_r  <= (axis_r < 3'd3) ? MUL_W'(RATE_K) : MUL_W'(ACC_K);
        mplier_r <= MB_W'(raw_mag);
        prod_r   <= '0;
      end
      ST_MUL: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      ST_SCALE: val_r[axis_r] <= scaled;
      ST_ACC: ;
      ST_DLOAD: begin
        dq_r    <= DIVD_W'(s_mag) + DIVD_W'(latched_r >> 1);
        dvs_r   <= DV_W'(latched_r);
        rem_r   <= '0;
        dsign_r <= s_sel[47];
      end
      ST_DIV: begin
        rem_r <= rem_ge ? DV_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DV_W-1:0];
        dq_r  <= {dq_r[DIVD_W-2:0], rem_ge};
      end
      ST_DOFF: ;
      ST_CORR: begin
        for (int i = 0; i < 6; i++) val_r[i] <= corr[i];
      end
      ST_YMLOAD: begin
        mcand_r  <= MUL_W'(t_mag);
        mplier_r <= MB_W'(dt_r);
        prod_r   <= '0;
        dsign_r  <= t33[32];
      end
      ST_YDLOAD: begin
        dq_r  <= {prod_r[DIVD_W-2:0], 1'b0} + DIVD_W'(YAW_RND);
        dvs_r <= DV_W'(YAW_DIV);
        rem_r <= '0;
      end
      ST_YAW1: y_r <= 42'(yaw_r) + inc42;
      ST_YAW2: ;
      ST_OUT: begin
        if (out_free) begin
          out_tdata_r <= {yaw_r, val_r[5], val_r[4], val_r[3], val_r[2], val_r[1], val_r[0]};
          out_tuser_r <= {active_r, done_r};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/imu_cal_chk.sv =====
// ---------------------------------------------------------------------------
// IMU calibration port checker
// Port-level properties of the calibration and yaw block, bound to the top.
// ---------------------------------------------------------------------------
`include "imu_bias_calibrate_yaw_integrate_top_defines.svh"

module imu_cal_chk #(
  parameter int OUT_W = 224
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [0:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser
);

  `IMU_CAL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `IMU_CAL_ASSERT_NOW(a_done_not_busy, out_tvalid, !(out_tuser[0] && out_tuser[1]))
  `IMU_CAL_ASSERT_NEXT(a_sample_busy, in_tvalid && in_tready && !in_tuser[0], !in_tready)
  `IMU_CAL_ASSERT_NEXT(a_start_quick, in_tvalid && in_tready && in_tuser[0], in_tready)

endmodule

bind imu_bias_calibrate_yaw_integrate_top imu_cal_chk u_imu_cal_chk (.*);

// ===== tb/imu_cal_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU calibration result checker
// Watches the input, config and result streams, predicts every sample
// result and compares it field by field against the block output.
// ---------------------------------------------------------------------------
module imu_cal_checker #(
  parameter int IN_W = 168
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [imu_cal_pkg::OUT_W-1:0] out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [imu_cal_pkg::CFG_W-1:0] cfg_wr_data,
  output int                            fail_count,
  output int                            pending
);
  import imu_cal_pkg::*;

  typedef struct packed {
    logic [1:0]        flags;
    logic [OUT_W-1:0]  data;
  } imu_result_t;

  localparam longint CNT_MAX = (64'd1 << COUNTER_WIDTH_DEF) - 1;

  imu_result_t    result_q[$];
  longint         rate_sum[3], acc_sum[3], rate_off[3], acc_off[3];
  longint         cal_cnt, cal_len, prev_rz, yaw;
  bit             cal_on;
  logic [15:0]    sample_cnt_reg;

  assign pending = result_q.size();

  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_sample(input logic [IN_W-1:0] d);
    longint rate[3], acc[3], res[6], g, a, inc, y;
    bit done;
    imu_result_t r;
    done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      g = longint'($signed(d[i*24 +: 24]));
      a = longint'($signed(d[(i+3)*24 +: 24]));
      rate[i] = clip(rdiv(g * 74961321, 64'd1 << 24), I32_MIN, I32_MAX);
      acc[i] = clip(rdiv(a * 642908, 64'd1 << 16), I32_MIN, I32_MAX);
      if (i != 1) begin
        rate[i] = clip(-rate[i], I32_MIN, I32_MAX);
        acc[i] = clip(-acc[i], I32_MIN, I32_MAX);
      end
    end
    if (cal_on) begin
      for (int i = 0; i < 3; i++) begin
        rate_sum[i] = clip(rate_sum[i] + rate[i], SUM_MIN, SUM_MAX);
        acc_sum[i] = clip(acc_sum[i] + acc[i] - (i == 2 ? 642908 : 0), SUM_MIN, SUM_MAX);
      end
      cal_cnt = (cal_cnt + 1) & CNT_MAX;
      if (cal_cnt == cal_len) begin
        for (int i = 0; i < 3; i++) begin
          rate_off[i] = clip(rdiv(rate_sum[i], cal_len), I32_MIN, I32_MAX);
          acc_off[i] = clip(rdiv(acc_sum[i], cal_len), I32_MIN, I32_MAX);
        end
        prev_rz = 0;
        yaw = 0;
        cal_on = 1'b0;
        done = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i] = clip(rate[i] - rate_off[i], I32_MIN, I32_MAX);
      res[i+3] = clip(acc[i] - acc_off[i], I32_MIN, I32_MAX);
    end
    inc = rdiv((res[2] + prev_rz) * longint'(d[6*24 +: 20]) * 2, 15625);
    y = yaw + inc;
    if (y > PI_Q28) y -= TWO_PI_Q28;
    else if (y < -PI_Q28) y += TWO_PI_Q28;
    yaw = clip(y, I32_MIN, I32_MAX);
    prev_rz = res[2];
    for (int i = 0; i < 6; i++) r.data[i*32 +: 32] = res[i][31:0];
    r.data[6*32 +: 32] = yaw[31:0];
    r.flags = {cal_on, done};
    result_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  string field_name[7] = '{"rate_x", "rate_y", "rate_z", "accel_x", "accel_y",
                           "accel_z", "heading"};

  always @(posedge clk) begin
    imu_result_t e;
    longint n;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        rate_sum[i] = 0; acc_sum[i] = 0; rate_off[i] = 0; acc_off[i] = 0;
      end
      cal_cnt = 0; cal_len = 1; cal_on = 0; prev_rz = 0; yaw = 0;
      sample_cnt_reg = CFG_RESET;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          e = result_q.pop_front();
          for (int i = 0; i < 7; i++)
            check_field(field_name[i], e.data[i*32 +: 32], out_tdata[i*32 +: 32]);
          check_field("calib_done", e.flags[0], out_tuser[0]);
          check_field("calibrating", e.flags[1], out_tuser[1]);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == KIND_START) begin
          if (!cal_on) begin
            n = sample_cnt_reg == 0 ? 1 : sample_cnt_reg;
            if (n > CNT_MAX) n = CNT_MAX;
            cal_len = n; cal_on = 1; cal_cnt = 0;
            for (int i = 0; i < 3; i++) begin
              rate_sum[i] = 0; acc_sum[i] = 0;
            end
          end
        end else begin
          predict_sample(in_tdata);
        end
      end
      if (cfg_wr_en) sample_cnt_reg = cfg_wr_data;
    end
  end
endmodule

// ===== tb/tb_imu_bias_calibrate_yaw_integrate_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU bias calibration and yaw integration testbench
// Directed extremes and calibration runs, then random sample streams with
// start requests, under random input gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_imu_bias_calibrate_yaw_integrate_top;
  import imu_cal_pkg::*;

  localparam int IN_W = ((6 * 24 + DT_W + 7) / 8) * 8;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic [0:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;
  longint           cycles;
  bit               stall_on;

  localparam longint CYCLE_LIMIT = 4000000;

  imu_bias_calibrate_yaw_integrate_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  imu_cal_checker #(.IN_W(IN_W)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** imu_bias_calibrate_yaw_integrate_top: FAILED **");
        $finish;
      end
    end
  end

  // output backpressure, random stalls, with stall-free stretches
  initial begin
    int w;
    out_tready = 1'b0;
    stall_on = 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
      if (out_tvalid && out_tready) begin
        w = stall_on ? $urandom_range(0, 8) : 0;
        if (w > 0) begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_tready <= 1'b1;
      end else if (!out_tready) begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [23:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      3: return 24'($signed($urandom_range(0, 200000)) - 100000);
      default: return 24'($urandom);
    endcase
  endfunction

  // tvalid stays high after the accepting edge; the next beat or an idle
  // step decides its level at that same edge
  task automatic send_beat(input logic kind, input logic [IN_W-1:0] d, input bit gap);
    int w;
    w = gap ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_sample(input logic [23:0] ax[6], input logic [19:0] dt);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 6; i++) d[i*24 +: 24] = ax[i];
    d[6*24 +: 20] = dt;
    send_beat(KIND_SAMPLE, d, $urandom_range(0, 3) != 0);
  endtask

  task automatic send_random_sample(input bit quiet);
    logic [23:0] ax[6];
    for (int i = 0; i < 6; i++)
      ax[i] = quiet ? 24'($signed($urandom_range(0, 4000)) - 2000) : rand_axis();
    send_sample(ax, $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 20000)));
  endtask

  task automatic send_start();
    send_beat(KIND_START, IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}),
              1'b1);
  endtask

  task automatic drain_then_write(input logic [15:0] v);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [23:0] ax[6];
    int sent;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes before and after a short calibration
    for (int i = 0; i < 6; i++) ax[i] = 24'h7FFFFF;
    send_sample(ax, 20'hFFFFF);
    for (int i = 0; i < 6; i++) ax[i] = 24'h800000;
    send_sample(ax, 20'hFFFFF);
    for (int i = 0; i < 6; i++) ax[i] = '0;
    send_sample(ax, '0);
    drain_then_write(16'd0);
    send_start();
    send_start();
    for (int i = 0; i < 6; i++) ax[i] = 24'h7FFFFF;
    send_sample(ax, 20'd10000);
    for (int i = 0; i < 6; i++) ax[i] = 24'h800000;
    send_sample(ax, 20'hFFFFF);
    send_sample(ax, 20'hFFFFF);
    drain_then_write(16'd3);
    send_start();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 6; i++) ax[i] = 24'h800000;
      send_sample(ax, 20'hFFFFF);
      if (k == 0) send_start();
    end
    for (int k = 0; k < 6; k++) send_random_sample(1'b0);

    // random phases across register settings
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: drain_then_write(16'd1);
        1: drain_then_write(16'hFFFF);
        2: drain_then_write(16'd100);
        default: drain_then_write($urandom_range(0, 40));
      endcase
      if (ph == 1) begin
        send_start();
        for (int k = 0; k < 80; k++) send_random_sample(1'b1);
        drain_then_write(16'd5);
        for (int k = 0; k < 40; k++) send_random_sample(1'b0);
      end else begin
        for (int k = 0; k < 200; k++) begin
          if ($urandom_range(0, 14) == 0) send_start();
          send_random_sample($urandom_range(0, 1) == 0);
        end
      end
      sent += 200;
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** imu_bias_calibrate_yaw_integrate_top: PASSED **");
    end else begin
      $display("** imu_bias_calibrate_yaw_integrate_top: FAILED **");
    end
    $finish;
  end
endmodule
